>>> rtl/core/gn2d_pkg.sv
`default_nettype none

package gn2d_pkg;

   // Coordinate format and internal fraction precision
   localparam int unsigned COORD_FRAC_BITS_DEFAULT = 16;
   localparam int unsigned Q_BITS = 24;

   // Corner hash constants
   localparam logic [31:0] HASH_MUL_X = 32'd374761393;
   localparam logic [31:0] HASH_MUL_Y = 32'd668265263;
   localparam logic [31:0] HASH_MUL_F = 32'd1274126177;
   localparam int unsigned HASH_SHIFT = 13;

   // Angle selection: hash mod 360 = ((hash >> 3) mod 45) * 8 + (hash & 7)
   localparam int unsigned ANGLE_COUNT = 360;
   localparam int unsigned MOD45_SHIFT = 36;
   localparam logic [30:0] MOD45_RECIP = 31'd1527099484;

   // Register map
   localparam logic [1:0] REG_SEED_ADDR = 2'd0;

   // Pi in Q30, used only to build the sine table
   localparam longint unsigned PI_Q30 = 64'd3373259426;

   // One item handed from the front to the back
   typedef struct packed {
      logic [3:0][31:0] hash;     // corner order 00, 01, 10, 11 (x then y)
      logic [24:0]      fade_u;
      logic [24:0]      fade_v;
      logic [23:0]      frac_x;
      logic [23:0]      frac_y;
   } front_item_type;

   typedef logic [127:0][15:0] sin_table_type;

   // Quarter-wave sine in Q1.15, whole degrees 0..90, Taylor series in Q30
   function automatic sin_table_type build_sin_table();
      sin_table_type     tbl;
      longint unsigned   x;
      longint unsigned   term;
      longint            sum;
      longint            q;
      tbl = '0;
      for (int d = 0; d <= 90; d++) begin
         x = (64'(d) * PI_Q30) / 64'd180;
         term = x;
         sum = longint'(x);
         for (int k = 1; k <= 8; k++) begin
            term = (((term * x) >> 30) * x) >> 30;
            term = term / 64'((2 * k) * (2 * k + 1));
            if ((k % 2) == 1) begin
               sum = sum - longint'(term);
            end else begin
               sum = sum + longint'(term);
            end
         end
         q = (sum + 64'sd16384) >>> 15;
         if (q > 64'sd32767) begin
            q = 64'sd32767;
         end
         if (q < 64'sd0) begin
            q = 64'sd0;
         end
         tbl[d] = q[15:0];
      end
      return tbl;
   endfunction

   localparam sin_table_type SIN_TABLE = build_sin_table();

   // Full-circle sine from the quarter table, angle in degrees 0..359
   function automatic logic signed [15:0] gn2d_sin(input logic [8:0] angle);
      logic [8:0]         idx;
      logic               neg;
      logic signed [15:0] mag;
      priority if (angle < 9'd90) begin
         idx = angle;
         neg = 1'b0;
      end else if (angle < 9'd180) begin
         idx = 9'd180 - angle;
         neg = 1'b0;
      end else if (angle < 9'd270) begin
         idx = angle - 9'd180;
         neg = 1'b1;
      end else begin
         idx = 9'd360 - angle;
         neg = 1'b1;
      end
      mag = $signed(SIN_TABLE[idx[6:0]]);
      return neg ? -mag : mag;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/gradient_noise_2d.sv
// Throughput: one point per cycle unless a full queue holds the pipeline; 4 front stages
// and 7 back stages each take a new point every cycle while not stalled, and all per-corner
// hashes and dot products run in parallel.
// A short queue between front and back and a 4-entry result queue absorb stalls.
// Reset (synchronous, active high) empties both queues and the pipelines and sets seed to 0.
`default_nettype none

module gradient_noise_2d #(
   parameter int unsigned COORD_FRAC_BITS = gn2d_pkg::COORD_FRAC_BITS_DEFAULT,
   parameter int unsigned MID_DEPTH = 4,
   parameter int unsigned OUT_DEPTH = 4
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // input channel
   input  wire logic               push,
   output logic                    full,
   input  wire logic signed [31:0] req_coord_x,
   input  wire logic signed [31:0] req_coord_y,
   // result channel
   output logic                    empty,
   input  wire logic               pop,
   output logic signed [15:0]      rsp_noise,
   // configuration port
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [1:0]         paddr,
   input  wire logic [31:0]        pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);

   import gn2d_pkg::*;

   logic [31:0]    seed_ff;
   logic           in_ready;
   logic           mid_push, mid_full, mid_empty, mid_pop;
   front_item_type front_item, back_item;
   logic           out_push, out_full;
   logic [15:0]    out_noise;
   logic [15:0]    rsp_data;

   // Configuration register
   assign pready = 1'b1;
   assign prdata = (paddr == REG_SEED_ADDR) ? seed_ff : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= '0;
      end else if (psel && penable && pwrite && pready && (paddr == REG_SEED_ADDR)) begin
         seed_ff <= pwdata;
      end
   end

   // Front: cell, fraction, corner hashes, fade weights
   gn2d_front #(
      .COORD_FRAC_BITS(COORD_FRAC_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .seed     (seed_ff),
      .in_valid (push),
      .coord_x  (req_coord_x),
      .coord_y  (req_coord_y),
      .in_ready (in_ready),
      .out_push (mid_push),
      .out_item (front_item),
      .out_full (mid_full)
   );

   assign full = !in_ready;

   // Queue between front and back
   gn2d_fifo #(
      .WIDTH($bits(front_item_type)),
      .DEPTH(MID_DEPTH)
   ) u_mid_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (mid_push),
      .wr_data (front_item),
      .full    (mid_full),
      .rd_en   (mid_pop),
      .rd_data (back_item),
      .empty   (mid_empty)
   );

   // Back: gradients, dot products, blend
   gn2d_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (!mid_empty),
      .item       (back_item),
      .item_pop   (mid_pop),
      .out_push   (out_push),
      .out_noise  (out_noise),
      .out_full   (out_full)
   );

   // Result queue
   gn2d_fifo #(
      .WIDTH(16),
      .DEPTH(OUT_DEPTH)
   ) u_out_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (out_push),
      .wr_data (out_noise),
      .full    (out_full),
      .rd_en   (pop && !empty),
      .rd_data (rsp_data),
      .empty   (empty)
   );

   assign rsp_noise = $signed(rsp_data);

endmodule

`default_nettype wire

>>> rtl/core/gn2d_fifo.sv
`default_nettype none

module gn2d_fifo #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr_en,
   input  wire logic [WIDTH-1:0] wr_data,
   output logic                  full,
   input  wire logic             rd_en,
   output logic [WIDTH-1:0]      rd_data,
   output logic                  empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // Pointer wrap works for any depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // Storage, no reset needed
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

   assign rd_data = entry_ff[rd_ptr_ff];
   assign full = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);

   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !full)
      else $error("queue write while full");

   a_no_underflow : assert property (@(posedge clock) disable iff (reset)
      rd_en |-> !empty)
      else $error("queue read while empty");

   a_count_hold : assert property (@(posedge clock) disable iff (reset)
      (wr_en == rd_en) |=> $stable(count_ff))
      else $error("queue count moved without a net transfer");

endmodule

`default_nettype wire

>>> rtl/core/gn2d_front.sv
`default_nettype none

module gn2d_front #(
   parameter int unsigned COORD_FRAC_BITS = gn2d_pkg::COORD_FRAC_BITS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [31:0]            seed,
   input  wire logic                   in_valid,
   input  wire logic signed [31:0]     coord_x,
   input  wire logic signed [31:0]     coord_y,
   output logic                        in_ready,
   output logic                        out_push,
   output gn2d_pkg::front_item_type    out_item,
   input  wire logic                   out_full
);

   import gn2d_pkg::*;

   localparam logic [31:0] FRAC_MASK = (32'd1 << COORD_FRAC_BITS) - 32'd1;
   localparam int unsigned FRAC_SHIFT = Q_BITS - COORD_FRAC_BITS;

   logic stage_en;
   logic v0_ff, v1_ff, v2_ff, v3_ff;

   // Stage 0: input capture
   logic signed [31:0] cx_ff, cy_ff;

   // Stage 1: cell, fraction, first hash products, fade square and polynomial
   logic [31:0]        cell_x_in, cell_y_in, fxw_in, fyw_in;
   logic [23:0]        fx_in, fy_in;
   logic [47:0]        sqx_in, sqy_in;
   logic signed [28:0] innx_in, inny_in;
   logic signed [53:0] tix_in, tiy_in;
   logic signed [29:0] polyx_in, polyy_in;
   logic [31:0]        px_ff, py_ff;
   logic [23:0]        fx1_ff, fy1_ff, t2x_ff, t2y_ff;
   logic signed [29:0] polyx1_ff, polyy1_ff;

   // Stage 2: seed mix and xor-shift, fade cube
   logic [1:0][31:0]   pxs_in, pys_in;
   logic [3:0][31:0]   mix_in;
   logic [47:0]        cbx_in, cby_in;
   logic [3:0][31:0]   mix_ff;
   logic [23:0]        fx2_ff, fy2_ff, t3x_ff, t3y_ff;
   logic signed [29:0] polyx2_ff, polyy2_ff;

   // Stage 3: final hash multiply, fade result
   logic [3:0][31:0]   hash_in;
   logic signed [54:0] fdx_in, fdy_in;
   logic [3:0][31:0]   hash_ff;
   logic [24:0]        u_ff, v_ff;
   logic [23:0]        fx3_ff, fy3_ff;

   // Whole front advances together; it holds only when its result cannot leave
   assign stage_en = !v3_ff || !out_full;
   assign in_ready = stage_en;
   assign out_push = v3_ff && !out_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (stage_en) begin
         v0_ff <= in_valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // Stage 1 logic
   always_comb begin
      cell_x_in = 32'(cx_ff >>> COORD_FRAC_BITS);
      cell_y_in = 32'(cy_ff >>> COORD_FRAC_BITS);
      fxw_in = (32'(cx_ff) & FRAC_MASK) << FRAC_SHIFT;
      fyw_in = (32'(cy_ff) & FRAC_MASK) << FRAC_SHIFT;
      fx_in = fxw_in[23:0];
      fy_in = fyw_in[23:0];
      sqx_in = {24'd0, fx_in} * {24'd0, fx_in};
      sqy_in = {24'd0, fy_in} * {24'd0, fy_in};
      // 6t - 15, then t * (6t - 15) rounded, plus 10
      innx_in = $signed({5'd0, fx_in}) * 29'sd6 - 29'sd251658240;
      inny_in = $signed({5'd0, fy_in}) * 29'sd6 - 29'sd251658240;
      tix_in = $signed({1'b0, fx_in}) * innx_in;
      tiy_in = $signed({1'b0, fy_in}) * inny_in;
      tix_in = tix_in + 54'sd8388608;
      tiy_in = tiy_in + 54'sd8388608;
      polyx_in = tix_in[53:24] + 30'sd167772160;
      polyy_in = tiy_in[53:24] + 30'sd167772160;
   end

   // Stage 2 logic: four corner seeds, then h ^ (h >> 13)
   always_comb begin
      pxs_in[0] = px_ff;
      pxs_in[1] = px_ff + HASH_MUL_X;
      pys_in[0] = py_ff;
      pys_in[1] = py_ff + HASH_MUL_Y;
      for (int k = 0; k < 4; k++) begin
         mix_in[k] = seed ^ pxs_in[k / 2] ^ pys_in[k % 2];
         mix_in[k] = mix_in[k] ^ (mix_in[k] >> HASH_SHIFT);
      end
      cbx_in = {24'd0, t2x_ff} * {24'd0, fx1_ff};
      cby_in = {24'd0, t2y_ff} * {24'd0, fy1_ff};
   end

   // Stage 3 logic
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         hash_in[k] = mix_ff[k] * HASH_MUL_F;
      end
      fdx_in = $signed({1'b0, t3x_ff}) * polyx2_ff + 55'sd8388608;
      fdy_in = $signed({1'b0, t3y_ff}) * polyy2_ff + 55'sd8388608;
   end

   // Pipeline payload
   always_ff @(posedge clock) begin
      if (stage_en) begin
         cx_ff <= coord_x;
         cy_ff <= coord_y;

         px_ff <= cell_x_in * HASH_MUL_X;
         py_ff <= cell_y_in * HASH_MUL_Y;
         fx1_ff <= fx_in;
         fy1_ff <= fy_in;
         t2x_ff <= sqx_in[47:24];
         t2y_ff <= sqy_in[47:24];
         polyx1_ff <= polyx_in;
         polyy1_ff <= polyy_in;

         mix_ff <= mix_in;
         fx2_ff <= fx1_ff;
         fy2_ff <= fy1_ff;
         t3x_ff <= cbx_in[47:24];
         t3y_ff <= cby_in[47:24];
         polyx2_ff <= polyx1_ff;
         polyy2_ff <= polyy1_ff;

         hash_ff <= hash_in;
         u_ff <= fdx_in[48:24];
         v_ff <= fdy_in[48:24];
         fx3_ff <= fx2_ff;
         fy3_ff <= fy2_ff;
      end
   end

   always_comb begin
      out_item.hash = hash_ff;
      out_item.fade_u = u_ff;
      out_item.fade_v = v_ff;
      out_item.frac_x = fx3_ff;
      out_item.frac_y = fy3_ff;
   end

endmodule

`default_nettype wire

>>> rtl/core/gn2d_back.sv
`default_nettype none

module gn2d_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   item_valid,
   input  gn2d_pkg::front_item_type    item,
   output logic                        item_pop,
   output logic                        out_push,
   output logic signed [15:0]          out_noise,
   input  wire logic                   out_full
);

   import gn2d_pkg::*;

   logic stage_en;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff;

   // Stage 1: quotient of (hash >> 3) / 45
   logic [3:0][59:0]   qprod_in;
   logic [3:0][23:0]   quo_ff;
   logic [3:0][31:0]   hash1_ff;
   logic [24:0]        u1_ff, v1_ff_p;
   logic [23:0]        fx1_ff, fy1_ff;

   // Stage 2: angle in degrees
   logic [3:0][28:0]   rem_in;
   logic [3:0][8:0]    angle_ff;
   logic [24:0]        u2_ff, v2_ff_p;
   logic [23:0]        fx2_ff, fy2_ff;

   // Stage 3: gradient lookup
   logic [3:0][8:0]    cos_ang_in;
   logic signed [3:0][15:0] gx_ff, gy_ff;
   logic [24:0]        u3_ff, v3_ff_p;
   logic [23:0]        fx3_ff, fy3_ff;

   // Stage 4: dot product terms
   logic signed [1:0][24:0] dx_in, dy_in;
   logic signed [3:0][40:0] prx_ff, pry_ff;
   logic [24:0]        u4_ff, v4_ff_p;

   // Stage 5: corner values
   logic signed [3:0][41:0] dot_in;
   logic signed [3:0][26:0] corner_ff;
   logic [24:0]        u5_ff, v5_ff_p;

   // Stage 6: blend along x
   logic signed [1:0][27:0] dxdiff_in, nx_in;
   logic signed [1:0][53:0] dxprod_in;
   logic signed [1:0][27:0] nx_ff;
   logic [24:0]        v6_ff_p;

   // Stage 7: blend along y, round and saturate
   logic signed [28:0] dydiff_in;
   logic signed [54:0] dyprod_in;
   logic signed [30:0] blend_in;
   logic signed [21:0] scaled_in;
   logic signed [15:0] noise_in;
   logic signed [15:0] noise_ff;

   assign stage_en = !v7_ff || !out_full;
   assign item_pop = stage_en && item_valid;
   assign out_push = v7_ff && !out_full;
   assign out_noise = noise_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else if (stage_en) begin
         v1_ff <= item_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
      end
   end

   // Reciprocal multiply, exact for 29-bit dividends
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         qprod_in[k] = {31'd0, item.hash[k][31:3]} * {29'd0, MOD45_RECIP};
      end
   end

   // Remainder mod 45, then put back the low three bits
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         rem_in[k] = hash1_ff[k][31:3] - 29'(quo_ff[k]) * 29'd45;
      end
   end

   // Cosine is the sine of the angle plus 90 degrees
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         cos_ang_in[k] = (angle_ff[k] >= 9'd270) ? angle_ff[k] - 9'd270
                                                 : angle_ff[k] + 9'd90;
      end
   end

   // Corner offsets: near corner t, far corner t - 1
   always_comb begin
      dx_in[0] = $signed({1'b0, fx3_ff});
      dx_in[1] = $signed({1'b1, fx3_ff});
      dy_in[0] = $signed({1'b0, fy3_ff});
      dy_in[1] = $signed({1'b1, fy3_ff});
   end

   // Q39 dot products rounded to Q24
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         dot_in[k] = 42'($signed(prx_ff[k])) + 42'($signed(pry_ff[k])) + 42'sd16384;
      end
   end

   // x blend: pair (00,10) and pair (01,11)
   always_comb begin
      for (int j = 0; j < 2; j++) begin
         dxdiff_in[j] = 28'($signed(corner_ff[2 + j])) - 28'($signed(corner_ff[j]));
         dxprod_in[j] = $signed(dxdiff_in[j]) * $signed({1'b0, u5_ff}) + 54'sd8388608;
         nx_in[j] = 28'($signed(corner_ff[j])) + dxprod_in[j][51:24];
      end
   end

   // y blend, Q24 to Q15 and clamp
   always_comb begin
      dydiff_in = 29'($signed(nx_ff[1])) - 29'($signed(nx_ff[0]));
      dyprod_in = dydiff_in * $signed({1'b0, v6_ff_p}) + 55'sd8388608;
      blend_in = 31'($signed(nx_ff[0])) + dyprod_in[54:24];
      blend_in = blend_in + 31'sd256;
      scaled_in = blend_in[30:9];
      if (scaled_in > 22'sd32767) begin
         noise_in = 16'sh7FFF;
      end else if (scaled_in < -22'sd32768) begin
         noise_in = 16'sh8000;
      end else begin
         noise_in = scaled_in[15:0];
      end
   end

   // Pipeline payload
   always_ff @(posedge clock) begin
      if (stage_en) begin
         for (int k = 0; k < 4; k++) begin
            quo_ff[k] <= qprod_in[k][MOD45_SHIFT +: 24];
            angle_ff[k] <= {rem_in[k][5:0], hash1_ff[k][2:0]};
            gy_ff[k] <= gn2d_sin(angle_ff[k]);
            gx_ff[k] <= gn2d_sin(cos_ang_in[k]);
            prx_ff[k] <= $signed(gx_ff[k]) * $signed(dx_in[k / 2]);
            pry_ff[k] <= $signed(gy_ff[k]) * $signed(dy_in[k % 2]);
            corner_ff[k] <= dot_in[k][41:15];
         end
         hash1_ff <= item.hash;
         u1_ff <= item.fade_u;
         v1_ff_p <= item.fade_v;
         fx1_ff <= item.frac_x;
         fy1_ff <= item.frac_y;

         u2_ff <= u1_ff;
         v2_ff_p <= v1_ff_p;
         fx2_ff <= fx1_ff;
         fy2_ff <= fy1_ff;

         u3_ff <= u2_ff;
         v3_ff_p <= v2_ff_p;
         fx3_ff <= fx2_ff;
         fy3_ff <= fy2_ff;

         u4_ff <= u3_ff;
         v4_ff_p <= v3_ff_p;

         u5_ff <= u4_ff;
         v5_ff_p <= v4_ff_p;

         nx_ff <= nx_in;
         v6_ff_p <= v5_ff_p;

         noise_ff <= noise_in;
      end
   end

   a_angle_range : assert property (@(posedge clock) disable iff (reset)
      v2_ff |-> (angle_ff[0] < 9'(ANGLE_COUNT)) && (angle_ff[1] < 9'(ANGLE_COUNT)) &&
                (angle_ff[2] < 9'(ANGLE_COUNT)) && (angle_ff[3] < 9'(ANGLE_COUNT)))
      else $error("corner angle out of range");

   a_hold_on_stall : assert property (@(posedge clock) disable iff (reset)
      (v7_ff && out_full) |=> v7_ff && $stable(noise_ff))
      else $error("result lost while output queue full");

   a_pop_needs_room : assert property (@(posedge clock) disable iff (reset)
      item_pop |-> !(v7_ff && out_full))
      else $error("item taken while back end stalled");

endmodule

`default_nettype wire

>>> tb/gradient_noise_2d_tb.sv
`timescale 1ns / 1ps

module gradient_noise_2d_tb;

   localparam int FRAC_BITS = 16;
   localparam int LATENCY = 12;
   localparam logic [31:0] MIX_X = 32'd374761393;
   localparam logic [31:0] MIX_Y = 32'd668265263;
   localparam logic [31:0] MIX_F = 32'd1274126177;
   localparam longint unsigned PI_Q30 = 64'd3373259426;
   localparam longint ONE_Q24 = 64'sd1 << 24;
   localparam logic [1:0] SEED_ADDR = 2'd0;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic full;
   logic signed [31:0] req_coord_x = '0;
   logic signed [31:0] req_coord_y = '0;
   logic empty;
   logic pop = 1'b0;
   logic signed [15:0] rsp_noise;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   gradient_noise_2d dut (
      .clock(clock), .reset(reset),
      .push(push), .full(full), .req_coord_x(req_coord_x), .req_coord_y(req_coord_y),
      .empty(empty), .pop(pop), .rsp_noise(rsp_noise),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #2 clock = ~clock;

   // predictor state
   logic [31:0] seed_model = '0;
   longint quarter_sine [0:90];
   logic signed [15:0] noise_expected [$];

   int errors = 0;
   int send_idle_pct = 33;
   int recv_idle_pct = 78;
   bit pressure_req = 1'b0;

   // sin(d deg) in Q1.15 by Q30 Taylor series, rounded half up
   function automatic longint sine_q15(int d);
      longint unsigned x, term;
      longint sum, q;
      x = (64'(d) * PI_Q30) / 64'd180;
      term = x;
      sum = longint'(x);
      for (int k = 1; k <= 8; k++) begin
         term = (((term * x) >> 30) * x) >> 30;
         term = term / 64'((2 * k) * (2 * k + 1));
         if (k % 2 == 1) sum = sum - longint'(term);
         else sum = sum + longint'(term);
      end
      q = (sum + 64'sd16384) >>> 15;
      if (q > 32767) q = 32767;
      if (q < 0) q = 0;
      return q;
   endfunction

   function automatic longint circle_sine(int a);
      case (a / 90)
         0: return quarter_sine[a % 90];
         1: return quarter_sine[90 - a % 90];
         2: return -quarter_sine[a % 90];
         default: return -quarter_sine[90 - a % 90];
      endcase
   endfunction

   function automatic longint round_down_shift(longint v, int s);
      return (v + (64'sd1 << (s - 1))) >>> s;
   endfunction

   // gradient at a hashed lattice corner dotted with the offset, Q24
   function automatic longint corner_dot(logic [31:0] cx, logic [31:0] cy,
                                         longint dx, longint dy);
      logic [31:0] h;
      int angle;
      h = seed_model ^ (cx * MIX_X) ^ (cy * MIX_Y);
      h = (h ^ (h >> 13)) * MIX_F;
      angle = int'(h % 32'd360);
      return round_down_shift(circle_sine((angle + 90) % 360) * dx
                              + circle_sine(angle) * dy, 15);
   endfunction

   function automatic longint quintic_fade(longint t);
      longint t2, t3, poly;
      t2 = (t * t) >>> 24;
      t3 = (t2 * t) >>> 24;
      poly = round_down_shift(t * (6 * t - 15 * ONE_Q24), 24) + 10 * ONE_Q24;
      return round_down_shift(t3 * poly, 24);
   endfunction

   function automatic longint lerp_q24(longint a, longint b, longint t);
      return a + round_down_shift((b - a) * t, 24);
   endfunction

   function automatic logic signed [15:0] noise_at(logic [31:0] px, logic [31:0] py);
      logic [31:0] x0, y0;
      longint xf, yf, n00, n01, n10, n11, u, v, r;
      x0 = $signed(px) >>> FRAC_BITS;
      y0 = $signed(py) >>> FRAC_BITS;
      xf = longint'({48'b0, px[15:0]}) << (24 - FRAC_BITS);
      yf = longint'({48'b0, py[15:0]}) << (24 - FRAC_BITS);
      n00 = corner_dot(x0, y0, xf, yf);
      n01 = corner_dot(x0, y0 + 32'd1, xf, yf - ONE_Q24);
      n10 = corner_dot(x0 + 32'd1, y0, xf - ONE_Q24, yf);
      n11 = corner_dot(x0 + 32'd1, y0 + 32'd1, xf - ONE_Q24, yf - ONE_Q24);
      u = quintic_fade(xf);
      v = quintic_fade(yf);
      r = round_down_shift(lerp_q24(lerp_q24(n00, n10, u), lerp_q24(n01, n11, u), v), 9);
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r[15:0];
   endfunction

   // one point transfer; idles a random number of cycles first
   task automatic send_point(logic [31:0] px, logic [31:0] py);
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_coord_x <= px;
      req_coord_y <= py;
      do @(posedge clock); while (full);
      noise_expected.push_back(noise_at(px, py));
   endtask

   task automatic write_seed(logic [31:0] value);
      psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
      paddr <= SEED_ADDR; pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      seed_model = value;
      // read back
      pwrite <= 1'b0; penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== value) begin
         errors++;
         if (errors <= 10) $display("seed readback: expected %h got %h", value, prdata);
      end
      psel <= 1'b0; penable <= 1'b0;
   endtask

   task automatic drain;
      push <= 1'b0;
      while (noise_expected.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // result side: check each transfer, then decide pop for the next cycle
   int hold_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            if (noise_expected.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected result noise=%0d", rsp_noise);
            end else begin
               if (rsp_noise !== noise_expected[0]) begin
                  errors++;
                  if (errors <= 10)
                     $display("noise mismatch: expected %0d got %0d",
                              noise_expected[0], rsp_noise);
               end
               void'(noise_expected.pop_front());
            end
         end
         if (pressure_req) begin
            pressure_req = 1'b0;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
         end else begin
            pop <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   typedef struct {
      logic [31:0] x;
      logic [31:0] y;
      bit          known;
      logic signed [15:0] want;
   } point_row_type;

   point_row_type directed_rows [] = '{
      '{32'h0000_0000, 32'h0000_0000, 1'b1, 16'sd0},
      '{32'h0001_0000, 32'h0002_0000, 1'b1, 16'sd0},
      '{32'h8000_0000, 32'h8000_0000, 1'b1, 16'sd0},
      '{32'h7FFF_0000, 32'h7FFF_0000, 1'b1, 16'sd0},
      '{32'hFFFF_0000, 32'h8000_0000, 1'b1, 16'sd0},
      '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 16'sd0},
      '{32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 16'sd0},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 16'sd0},
      '{32'h8000_0001, 32'h8000_0001, 1'b0, 16'sd0},
      '{32'h0000_8000, 32'h0000_8000, 1'b0, 16'sd0},
      '{32'h0000_FFFF, 32'h0000_0000, 1'b0, 16'sd0},
      '{32'h0000_0000, 32'h0000_FFFF, 1'b0, 16'sd0},
      '{32'h0000_0001, 32'h0000_0001, 1'b0, 16'sd0},
      '{32'hFFFF_8000, 32'h0001_8000, 1'b0, 16'sd0},
      '{32'h7FFF_FFFF, 32'h8000_0001, 1'b0, 16'sd0},
      '{32'h1234_5678, 32'h9ABC_DEF0, 1'b0, 16'sd0},
      '{32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 16'sd0},
      '{32'h5555_AAAA, 32'hAAAA_5555, 1'b0, 16'sd0},
      '{32'h0003_4000, 32'hFFFD_C000, 1'b0, 16'sd0}
   };

   // mix of full-range, near-origin, lattice-aligned and cell-edge points
   function automatic logic [31:0] random_coord();
      case ($urandom_range(5))
         0, 1: return $urandom;
         2: return $signed(32'($urandom_range(20 << 16))) - (10 << 16);
         3: return {16'($urandom_range(65535)), 16'h0000};
         4: return {16'($urandom_range(65535)), 16'($urandom_range(3))};
         default: return {16'($urandom_range(65535)), 16'(16'hFFFF - $urandom_range(3))};
      endcase
   endfunction

   initial begin
      logic [31:0] phase_seed [3];
      for (int d = 0; d <= 90; d++) quarter_sine[d] = sine_q15(d);
      phase_seed[0] = 32'hFFFF_FFFF;
      phase_seed[1] = $urandom;
      phase_seed[2] = 32'h0000_0001;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_seed(32'h0000_0000);

      // directed points, lattice-aligned ones have a known zero result
      foreach (directed_rows[i]) begin
         send_point(directed_rows[i].x, directed_rows[i].y);
         if (directed_rows[i].known && noise_expected[$] !== directed_rows[i].want) begin
            errors++;
            if (errors <= 10) $display("row %0d: predictor gives %0d, table %0d",
                                       i, noise_expected[$], directed_rows[i].want);
         end
      end
      drain();

      for (int phase = 0; phase < 3; phase++) begin
         write_seed(phase_seed[phase]);
         send_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 78 : 0;
         recv_idle_pct = (phase == 0) ? 78 : (phase == 1) ? 33 : 0;
         if (phase == 2) pressure_req = 1'b1;
         for (int n = 0; n < 530; n++) send_point(random_coord(), random_coord());
         drain();
      end

      if (errors == 0) begin
         $display("gradient_noise_2d regression: pass");
      end else begin
         $display("gradient_noise_2d regression: fail");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("gradient_noise_2d regression: fail");
      $finish;
   end

endmodule

>>> gradient_noise_2d.f
rtl/core/gn2d_pkg.sv
rtl/core/gn2d_fifo.sv
rtl/core/gn2d_front.sv
rtl/core/gn2d_back.sv
rtl/core/gradient_noise_2d.sv
tb/gradient_noise_2d_tb.sv
